[rtl/qrot_pkg.sv]
// Shared widths, payload types and constants for the quaternion rotation block.
`default_nettype none

package qrot_pkg;

	localparam int DATA_W        = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int EPS_W         = 16;
	localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

	// Sum of four squares, unsigned.
	localparam int N_W = 2 * DATA_W + 1;
	// Wide multiplier operand (s, 2*dot, cross terms), signed.
	localparam int P_W = 2 * DATA_W + 2;
	// Narrow multiplier operand and quotient width.
	localparam int Q_W = DATA_W + 1;
	// Rotated numerator, signed.
	localparam int T_W = 3 * DATA_W + 6;
	// Rounded dividend, unsigned.
	localparam int D_W = T_W + 1;
	// Divider partial remainder.
	localparam int R_W = 2 * DATA_W + 3;

	typedef struct packed {
		logic signed [DATA_W-1:0] quat_x;
		logic signed [DATA_W-1:0] quat_y;
		logic signed [DATA_W-1:0] quat_z;
		logic signed [DATA_W-1:0] quat_w;
		logic signed [DATA_W-1:0] vec_x;
		logic signed [DATA_W-1:0] vec_y;
		logic signed [DATA_W-1:0] vec_z;
	} qrot_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rot_x;
		logic signed [DATA_W-1:0] rot_y;
		logic signed [DATA_W-1:0] rot_z;
		logic                     degenerate;
		logic                     saturated;
	} qrot_out_t;

	// Per-item sideband that bypasses the dividers.
	typedef struct packed {
		logic                     deg;
		logic signed [DATA_W-1:0] vec_x;
		logic signed [DATA_W-1:0] vec_y;
		logic signed [DATA_W-1:0] vec_z;
	} qrot_side_t;

	// One component's division job: round(num / n) set up as dnum / dden.
	typedef struct packed {
		logic [D_W-1:0] dnum;
		logic [P_W-1:0] dden;
		logic           neg;
	} qrot_div_in_t;

endpackage

`default_nettype wire

[rtl/qrot_front.sv]
// Six-stage multiply and accumulate front end: norm, degenerate test, rotated numerators.
`default_nettype none

module qrot_front import qrot_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_vld,
	input  wire qrot_in_t         in_item,
	input  wire logic [EPS_W-1:0] eps,
	output      logic             side_vld,
	output      qrot_side_t       side,
	output      qrot_div_in_t     div_x,
	output      qrot_div_in_t     div_y,
	output      qrot_div_in_t     div_z
);

	localparam int CMP_W = N_W + 2 * EPS_W + 2 * FRAC_BITS;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	// stage 1: squares and pairwise products
	logic signed [2*DATA_W-1:0] xx_s1, yy_s1, zz_s1, ww_s1;
	logic signed [2*DATA_W-1:0] xa_s1, yb_s1, zc_s1, yc_s1, zb_s1, za_s1, xc_s1, xb_s1, ya_s1;
	logic signed [DATA_W-1:0]   x_s1, y_s1, z_s1, w_s1, a_s1, b_s1, c_s1;

	// stage 2: norm, scalar term, dot and cross
	logic        [N_W-1:0]      n_s2;
	logic signed [N_W-1:0]      s_s2, cx_s2, cy_s2, cz_s2;
	logic signed [P_W-1:0]      dot2_s2;
	logic signed [Q_W-1:0]      w2_s2;
	logic signed [DATA_W-1:0]   x_s2, y_s2, z_s2, a_s2, b_s2, c_s2;

	// stage 3: split partial products
	logic signed [P_W-1:0]      ph_s3 [9];
	logic signed [P_W:0]        pl_s3 [9];
	logic        [N_W-1:0]      n_s3;
	qrot_side_t                 side_s3;

	// stage 4: full products
	logic signed [T_W-1:0]      t_s4 [9];
	logic        [N_W-1:0]      n_s4;
	qrot_side_t                 side_s4;

	// stage 5: numerators
	logic signed [T_W-1:0]      nn_s5 [3];
	logic        [N_W-1:0]      n_s5;
	qrot_side_t                 side_s5;

	// stage 6: division setup
	qrot_div_in_t               div_s6 [3];
	qrot_side_t                 side_s6;

	logic signed [P_W-1:0]      wop [9];
	logic signed [Q_W-1:0]      nop [9];
	logic signed [Q_W-1:0]      hi_d [9];
	logic signed [Q_W:0]        lo_d [9];
	logic signed [P_W-1:0]      ph_d [9];
	logic signed [P_W:0]        pl_d [9];
	logic        [2*EPS_W-1:0]  eps_sq;
	logic        [CMP_W-1:0]    norm_cmp, eps_cmp;
	logic                       deg_d;
	logic        [T_W-1:0]      mag_d [3];
	logic                       neg_d [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_comb begin
		eps_sq   = eps * eps;
		norm_cmp = CMP_W'(n_s2) << (2 * EPS_W);
		eps_cmp  = CMP_W'(eps_sq) << (2 * FRAC_BITS);
		deg_d    = (n_s2 == '0) || (norm_cmp < eps_cmp);

		wop[0] = P_W'(s_s2);  nop[0] = Q_W'(a_s2);
		wop[1] = dot2_s2;     nop[1] = Q_W'(x_s2);
		wop[2] = P_W'(cx_s2); nop[2] = w2_s2;
		wop[3] = P_W'(s_s2);  nop[3] = Q_W'(b_s2);
		wop[4] = dot2_s2;     nop[4] = Q_W'(y_s2);
		wop[5] = P_W'(cy_s2); nop[5] = w2_s2;
		wop[6] = P_W'(s_s2);  nop[6] = Q_W'(c_s2);
		wop[7] = dot2_s2;     nop[7] = Q_W'(z_s2);
		wop[8] = P_W'(cz_s2); nop[8] = w2_s2;

		// split each wide operand into a signed high half and an unsigned low half
		for (int i = 0; i < 9; i++) begin
			hi_d[i] = $signed(wop[i][P_W-1:Q_W]);
			lo_d[i] = $signed({1'b0, wop[i][Q_W-1:0]});
			ph_d[i] = hi_d[i] * nop[i];
			pl_d[i] = lo_d[i] * nop[i];
		end

		for (int j = 0; j < 3; j++) begin
			neg_d[j] = nn_s5[j][T_W-1];
			mag_d[j] = neg_d[j] ? T_W'(-nn_s5[j]) : T_W'(nn_s5[j]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xx_s1 <= in_item.quat_x * in_item.quat_x;
			yy_s1 <= in_item.quat_y * in_item.quat_y;
			zz_s1 <= in_item.quat_z * in_item.quat_z;
			ww_s1 <= in_item.quat_w * in_item.quat_w;
			xa_s1 <= in_item.quat_x * in_item.vec_x;
			yb_s1 <= in_item.quat_y * in_item.vec_y;
			zc_s1 <= in_item.quat_z * in_item.vec_z;
			yc_s1 <= in_item.quat_y * in_item.vec_z;
			zb_s1 <= in_item.quat_z * in_item.vec_y;
			za_s1 <= in_item.quat_z * in_item.vec_x;
			xc_s1 <= in_item.quat_x * in_item.vec_z;
			xb_s1 <= in_item.quat_x * in_item.vec_y;
			ya_s1 <= in_item.quat_y * in_item.vec_x;
			x_s1  <= in_item.quat_x;
			y_s1  <= in_item.quat_y;
			z_s1  <= in_item.quat_z;
			w_s1  <= in_item.quat_w;
			a_s1  <= in_item.vec_x;
			b_s1  <= in_item.vec_y;
			c_s1  <= in_item.vec_z;

			n_s2    <= N_W'($unsigned(xx_s1)) + N_W'($unsigned(yy_s1))
				+ N_W'($unsigned(zz_s1)) + N_W'($unsigned(ww_s1));
			s_s2    <= N_W'(ww_s1) - N_W'(xx_s1) - N_W'(yy_s1) - N_W'(zz_s1);
			dot2_s2 <= (P_W'(xa_s1) + P_W'(yb_s1) + P_W'(zc_s1)) <<< 1;
			cx_s2   <= N_W'(yc_s1) - N_W'(zb_s1);
			cy_s2   <= N_W'(za_s1) - N_W'(xc_s1);
			cz_s2   <= N_W'(xb_s1) - N_W'(ya_s1);
			w2_s2   <= Q_W'(w_s1) <<< 1;
			x_s2    <= x_s1;
			y_s2    <= y_s1;
			z_s2    <= z_s1;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			c_s2    <= c_s1;

			for (int i = 0; i < 9; i++) begin
				ph_s3[i] <= ph_d[i];
				pl_s3[i] <= pl_d[i];
			end
			n_s3          <= n_s2;
			side_s3.deg   <= deg_d;
			side_s3.vec_x <= a_s2;
			side_s3.vec_y <= b_s2;
			side_s3.vec_z <= c_s2;

			for (int i = 0; i < 9; i++) begin
				t_s4[i] <= (T_W'(ph_s3[i]) <<< Q_W) + T_W'(pl_s3[i]);
			end
			n_s4    <= n_s3;
			side_s4 <= side_s3;

			for (int j = 0; j < 3; j++) begin
				nn_s5[j] <= t_s4[3*j] + t_s4[3*j+1] + t_s4[3*j+2];
			end
			n_s5    <= n_s4;
			side_s5 <= side_s4;

			// round to nearest, ties away: (2|N| + n) / (2n)
			for (int j = 0; j < 3; j++) begin
				div_s6[j].dnum <= (D_W'(mag_d[j]) << 1) + D_W'(n_s5);
				div_s6[j].dden <= P_W'(n_s5) << 1;
				div_s6[j].neg  <= neg_d[j];
			end
			side_s6 <= side_s5;
		end
	end

	assign side_vld = vld_s6;
	assign side     = side_s6;
	assign div_x    = div_s6[0];
	assign div_y    = div_s6[1];
	assign div_z    = div_s6[2];

endmodule

`default_nettype wire

[rtl/qrot_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with signed saturation.
`default_nettype none

module qrot_div import qrot_pkg::*; (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire qrot_div_in_t       din,
	output      logic signed [DATA_W-1:0] rot,
	output      logic               sat
);

	logic [R_W-1:0] rem_s [1:Q_W];
	logic [Q_W-1:0] lo_s  [1:Q_W];
	logic [Q_W-1:0] quo_s [1:Q_W];
	logic [P_W-1:0] den_s [1:Q_W];
	logic           neg_s [1:Q_W];

	logic [R_W-1:0] cur_rem [Q_W];
	logic [Q_W-1:0] cur_lo  [Q_W];
	logic [Q_W-1:0] cur_quo [Q_W];
	logic [P_W-1:0] cur_den [Q_W];
	logic           cur_neg [Q_W];

	logic [Q_W-1:0] lim, qv;

	always_comb begin
		// the quotient fits in Q_W bits, so the top of the dividend is already below the divisor
		cur_rem[0] = din.dnum[Q_W+R_W-1:Q_W];
		cur_lo[0]  = din.dnum[Q_W-1:0];
		cur_quo[0] = '0;
		cur_den[0] = din.dden;
		cur_neg[0] = din.neg;
		for (int k = 1; k < Q_W; k++) begin
			cur_rem[k] = rem_s[k];
			cur_lo[k]  = lo_s[k];
			cur_quo[k] = quo_s[k];
			cur_den[k] = den_s[k];
			cur_neg[k] = neg_s[k];
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [R_W-1:0] trial;
		logic           ge;

		always_comb begin
			trial = {cur_rem[k][R_W-2:0], cur_lo[k][Q_W-1]};
			ge    = trial >= R_W'(cur_den[k]);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? trial - R_W'(cur_den[k]) : trial;
				lo_s[k+1]  <= cur_lo[k] << 1;
				quo_s[k+1] <= {cur_quo[k][Q_W-2:0], ge};
				den_s[k+1] <= cur_den[k];
				neg_s[k+1] <= cur_neg[k];
			end
		end
	end

	always_comb begin
		lim = neg_s[Q_W] ? (Q_W'(1) << (DATA_W - 1)) : ((Q_W'(1) << (DATA_W - 1)) - Q_W'(1));
		sat = quo_s[Q_W] > lim;
		qv  = sat ? lim : quo_s[Q_W];
		rot = neg_s[Q_W] ? -$signed(qv[DATA_W-1:0]) : $signed(qv[DATA_W-1:0]);
	end

endmodule

`default_nettype wire

[rtl/qrot_skid.sv]
// Output register with one skid entry; the pipeline freezes only while the skid entry is full.
`default_nettype none

module qrot_skid import qrot_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire qrot_out_t din,
	output      logic      full,
	output      logic      out_valid,
	input  wire logic      out_stall,
	output      qrot_out_t out_item
);

	logic      vld_q, skid_vld_q;
	qrot_out_t out_q, skid_q;
	logic      out_free;

	assign out_free = !vld_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			vld_q      <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : din;
		end else if (push) begin
			skid_q <= din;
		end
	end

	assign full      = skid_vld_q;
	assign out_valid = vld_q;
	assign out_item  = out_q;

	a_skid_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(vld_q && out_stall))
		else $error("skid entry filled while output was free");

	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> vld_q)
		else $error("skid entry held with empty output register");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> !push)
		else $error("item pushed into full skid stage");

endmodule

`default_nettype wire

[rtl/quaternion_rotate_vector.sv]
// Top level of the quaternion vector rotation pipeline.
`default_nettype none

// Rotates one Q16.16 vector by a quaternion per clock while in_stall is low: every such cycle
// a new item may enter, passing through 6 multiply/accumulate stages, a 33-stage divider that
// retires one quotient bit per stage, and the output register. The rotation is computed
// exactly as q*(v,0)*conj(q) divided by the squared norm, rounded to nearest with ties away
// from zero, then clipped to the 32-bit range (saturated flags any clipped component). A
// quaternion whose length is below epsilon_q16, or is zero, returns the vector unchanged with
// degenerate set. in_stall rises only when one finished item waits in the skid entry behind
// a stalled output; the whole pipeline then holds. Write epsilon only while no item is in
// flight.
module quaternion_rotate_vector import qrot_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [EPS_W-1:0] cfg_wr_data,
	input  wire logic             in_valid,
	output      logic             in_stall,
	input  wire qrot_in_t         in_item,
	output      logic             out_valid,
	input  wire logic             out_stall,
	output      qrot_out_t        out_item
);

	logic [EPS_W-1:0] eps_q;
	logic             en;
	logic             skid_full;
	logic             side_vld;
	qrot_side_t       side;
	qrot_div_in_t     div_x, div_y, div_z;
	logic signed [DATA_W-1:0] rot_x, rot_y, rot_z;
	logic             sat_x, sat_y, sat_z;
	logic             sv_s [1:Q_W];
	qrot_side_t       sd_s [1:Q_W];
	qrot_out_t        res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_RESET;
		end else if (cfg_wr_en) begin
			eps_q <= cfg_wr_data;
		end
	end

	assign en       = !skid_full;
	assign in_stall = skid_full;

	qrot_front #(
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (in_valid),
		.in_item  (in_item),
		.eps      (eps_q),
		.side_vld (side_vld),
		.side     (side),
		.div_x    (div_x),
		.div_y    (div_y),
		.div_z    (div_z)
	);

	qrot_div u_div_x (.clk(clk), .en(en), .din(div_x), .rot(rot_x), .sat(sat_x));
	qrot_div u_div_y (.clk(clk), .en(en), .din(div_y), .rot(rot_y), .sat(sat_y));
	qrot_div u_div_z (.clk(clk), .en(en), .din(div_z), .rot(rot_z), .sat(sat_z));

	// carry valid and bypass data alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= Q_W; k++) begin
				sv_s[k] <= 1'b0;
			end
		end else if (en) begin
			sv_s[1] <= side_vld;
			for (int k = 2; k <= Q_W; k++) begin
				sv_s[k] <= sv_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s[1] <= side;
			for (int k = 2; k <= Q_W; k++) begin
				sd_s[k] <= sd_s[k-1];
			end
		end
	end

	always_comb begin
		if (sd_s[Q_W].deg) begin
			res.rot_x     = sd_s[Q_W].vec_x;
			res.rot_y     = sd_s[Q_W].vec_y;
			res.rot_z     = sd_s[Q_W].vec_z;
			res.saturated = 1'b0;
		end else begin
			res.rot_x     = rot_x;
			res.rot_y     = rot_y;
			res.rot_z     = rot_z;
			res.saturated = sat_x || sat_y || sat_z;
		end
		res.degenerate = sd_s[Q_W].deg;
	end

	qrot_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && sv_s[Q_W]),
		.din       (res),
		.full      (skid_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	a_degenerate_not_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.degenerate |-> !out_item.saturated)
		else $error("degenerate item reported as saturated");

endmodule

`default_nettype wire

[sim/tb.sv]
// Self-checking testbench for the quaternion vector rotation block.
`default_nettype none

module tb;
	import qrot_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = FRAC_BITS_DEF;

	logic             clk;
	logic             arst_n;
	logic             cfg_wr_en;
	logic [EPS_W-1:0] cfg_wr_data;
	logic             in_valid;
	logic             in_stall;
	qrot_in_t         in_item;
	logic             out_valid;
	logic             out_stall;
	qrot_out_t        out_item;

	quaternion_rotate_vector u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

	logic [EPS_W-1:0] eps_shadow;
	qrot_out_t        rotations_due[$];
	int               errors;
	bit               send_busy;   // sender idles at random when set
	bit               recv_busy;   // receiver stalls at random when set

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("quaternion_rotate_vector regression: fail");
		$finish;
	end

	// Round num/n to nearest, ties away from zero, then clip to the data range.
	function automatic logic signed [DATA_W-1:0] round_clip(
		input logic signed [255:0] num, input logic signed [255:0] n, inout bit sat);
		logic signed [255:0] mag, q;
		logic signed [255:0] hi, lo;
		mag = (num < 0) ? -num : num;
		q   = (2 * mag + n) / (2 * n);
		if (num < 0) q = -q;
		hi = (256'sd1 <<< (DATA_W - 1)) - 1;
		lo = -(256'sd1 <<< (DATA_W - 1));
		if (q > hi) begin
			q = hi;
			sat = 1;
		end else if (q < lo) begin
			q = lo;
			sat = 1;
		end
		return q[DATA_W-1:0];
	endfunction

	function automatic qrot_out_t rotate_vector(input qrot_in_t it, input logic [EPS_W-1:0] eps);
		logic signed [255:0] x, y, z, w, a, b, c, n, s, dot2, w2, nx, ny, nz;
		logic [255:0] lhs, rhs;
		qrot_out_t r;
		bit sat;
		x = it.quat_x; y = it.quat_y; z = it.quat_z; w = it.quat_w;
		a = it.vec_x; b = it.vec_y; c = it.vec_z;
		n = x*x + y*y + z*z + w*w;
		lhs = n << 32;
		rhs = (256'(eps) * 256'(eps)) << (2 * FB);
		sat = 0;
		if (n == 0 || lhs < rhs) begin
			r.rot_x = it.vec_x; r.rot_y = it.vec_y; r.rot_z = it.vec_z;
			r.degenerate = 1'b1;
			r.saturated = 1'b0;
			return r;
		end
		s = w*w - x*x - y*y - z*z;
		dot2 = 2 * (x*a + y*b + z*c);
		w2 = 2 * w;
		nx = s*a + dot2*x + w2*(y*c - z*b);
		ny = s*b + dot2*y + w2*(z*a - x*c);
		nz = s*c + dot2*z + w2*(x*b - y*a);
		r.rot_x = round_clip(nx, n, sat);
		r.rot_y = round_clip(ny, n, sat);
		r.rot_z = round_clip(nz, n, sat);
		r.degenerate = 1'b0;
		r.saturated = sat;
		return r;
	endfunction

	// Receiver: stall at random, check each accepted item against the oldest prediction.
	always @(posedge clk) begin
		qrot_out_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (rotations_due.size() == 0) begin
					$error("unexpected result item");
					errors++;
				end else begin
					e = rotations_due.pop_front();
					if (out_item.rot_x !== e.rot_x) begin
						$error("rot_x expected %0d actual %0d", e.rot_x, out_item.rot_x);
						errors++;
					end
					if (out_item.rot_y !== e.rot_y) begin
						$error("rot_y expected %0d actual %0d", e.rot_y, out_item.rot_y);
						errors++;
					end
					if (out_item.rot_z !== e.rot_z) begin
						$error("rot_z expected %0d actual %0d", e.rot_z, out_item.rot_z);
						errors++;
					end
					if (out_item.degenerate !== e.degenerate) begin
						$error("degenerate expected %0b actual %0b", e.degenerate,
							out_item.degenerate);
						errors++;
					end
					if (out_item.saturated !== e.saturated) begin
						$error("saturated expected %0b actual %0b", e.saturated,
							out_item.saturated);
						errors++;
					end
				end
			end
			out_stall <= recv_busy && ($urandom_range(99) < 18);
		end
	end

	// Leave in_valid high after the accepting edge; drain() or an idle turn of the next call drops it.
	task automatic send_item(input qrot_in_t it);
		while (send_busy && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= it;
		rotations_due.push_back(rotate_vector(it, eps_shadow));
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (rotations_due.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	task automatic write_epsilon(input logic [EPS_W-1:0] v);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		eps_shadow = v;
	endtask

	function automatic logic [DATA_W-1:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(131072)) - 65536);
			3: return 32'($signed($urandom_range(8)) - 4);
			default: return $urandom;
		endcase
	endfunction

	function automatic qrot_in_t make_item(input logic [DATA_W-1:0] qx, qy, qz, qw,
		input logic [DATA_W-1:0] vx, vy, vz);
		qrot_in_t it;
		it.quat_x = qx; it.quat_y = qy; it.quat_z = qz; it.quat_w = qw;
		it.vec_x = vx; it.vec_y = vy; it.vec_z = vz;
		return it;
	endfunction

	task automatic test_directed();
		// identity, axis turns, zero quaternion, extremes, tiny lengths
		send_item(make_item(0, 0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h30000));
		send_item(make_item(32'h10000, 0, 0, 0, 32'h10000, 32'h20000, 32'h30000));
		send_item(make_item(0, 32'h10000, 0, 0, 32'h10000, 32'h20000, 32'h30000));
		send_item(make_item(0, 0, 32'h10000, 32'h10000, 32'h10000, 0, 0));
		send_item(make_item(0, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h1234));
		send_item(make_item(1, 0, 0, 0, 5, 6, 7));
		send_item(make_item(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0));
		send_item(make_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
		send_item(make_item(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_item(make_item(32'h10000, 32'h10000, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 0));
		send_item(make_item(32'h10000, 0, 32'h10000, 32'h10000, 32'h8000_0000, 3, 32'hffffffff));
		send_item(make_item(0, 0, 0, 32'hffffffff, 1, 2, 3));
		send_item(make_item(0, 32'hffff_ffff, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 1));
	endtask

	task automatic test_epsilon_sweep();
		logic [EPS_W-1:0] settings[5] = '{16'h0000, 16'hffff, 16'h8000, 16'h0100, 16'h0001};
		int t;
		logic [DATA_W-1:0] m;
		foreach (settings[k]) begin
			write_epsilon(settings[k]);
			for (t = 0; t < 8; t++) begin
				// lengths near epsilon
				m = 32'(settings[k]) + 32'($signed($urandom_range(4)) - 2);
				send_item(make_item((t & 1) ? m : 0, (t & 2) ? m : 0, 0, (t & 4) ? 0 : m,
					$urandom, $urandom, $urandom));
			end
		end
	endtask

	task automatic test_random(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			send_busy = !(i >= count / 3 && i < count / 2);
			recv_busy = send_busy;
			if (i == count / 2) drain();
			send_item(make_item(rand_word(), rand_word(), rand_word(), rand_word(),
				rand_word(), rand_word(), rand_word()));
		end
		send_busy = 1;
		recv_busy = 1;
	endtask

	initial begin
		errors      = 0;
		eps_shadow  = EPS_RESET;
		send_busy   = 1;
		recv_busy   = 1;
		arst_n      = 1'b0;
		cfg_wr_en   = 1'b0;
		cfg_wr_data = '0;
		in_valid    = 1'b0;
		in_item     = '0;
		out_stall   = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_epsilon_sweep();
		write_epsilon(16'h0040);
		test_random(700);
		write_epsilon(EPS_W'($urandom));
		test_random(600);
		drain();
		if (errors == 0 && rotations_due.size() == 0) begin
			$display("quaternion_rotate_vector regression: pass");
		end else begin
			$display("quaternion_rotate_vector regression: fail");
		end
		$finish;
	end
endmodule

`default_nettype wire
